FILE: rtl/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_e;

  typedef enum logic [2:0] {
    EV_MSG_BYTE,
    EV_PING_BYTE,
    EV_EMPTY_MSG,
    EV_EMPTY_PING,
    EV_CLOSE,
    EV_TOO_LONG
  } event_e;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        fin;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/websocket_frame_deframer.sv
`default_nettype none

// Receive-side WebSocket frame deframer. One stream byte is taken per
// transaction on s_axis and parsed in the same cycle; at most one result per
// byte lands in a two-entry output buffer whose registers drive m_axis; the
// block takes one byte every cycle as long as m_axis drains at that rate
// (s_axis_tready drops only when both buffer entries are full). A close
// frame or a length above max_payload_length stops the parser; later bytes
// are accepted and dropped until reset.
// max_payload_length is written through cfg_* and resets to 1048576.

module websocket_frame_deframer import wsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] opcode,
                                           // [12] final_fragment, [15:13] zero
  output      logic [2:0]  m_axis_tuser,   // [2:0] event_res
  output      logic        m_axis_tlast,   // last_of_frame
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0] max_len_q;
  logic        accept;
  logic        res_valid;
  res_t        res;
  res_t        out_res;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_byte_i   (s_axis_tdata),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_res_i    (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, out_res.fin, out_res.opcode, out_res.data};
  assign m_axis_tuser = out_res.ev;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

FILE: rtl/wsd_parser.sv
`default_nettype none

module wsd_parser import wsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic [31:0] max_len_i,
  output      logic        res_valid_o,
  output      res_t        res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  op_q, op_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  left_q, left_d;
  logic [31:0] key_q, key_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  idx_q, idx_d;

  logic [63:0] len_cand;
  logic [3:0]  left_dec;
  logic [31:0] rem_dec;
  logic        rem_last;
  logic        too_long;
  logic        short_len;
  logic        len_fire;
  logic        mask_now;
  logic        bp_fire;
  logic [31:0] bp_rem;
  logic        bp_empty;
  logic        is_msg, is_ping, is_close;
  logic [7:0]  key_byte;

  assign short_len = (in_byte_i[6:0] != LEN_EXT16) && (in_byte_i[6:0] != LEN_EXT64);
  assign len_cand  = (phase_q == PH_HDR1) ? {57'd0, in_byte_i[6:0]} : {len_q[55:0], in_byte_i};
  assign left_dec  = left_q - 4'd1;
  assign rem_dec   = rem_q - 32'd1;
  assign rem_last  = (rem_dec == 32'd0);
  assign too_long  = (|len_cand[63:32]) || (len_cand[31:0] > max_len_i);
  assign len_fire  = ((phase_q == PH_HDR1) && short_len) ||
                     ((phase_q == PH_EXTLEN) && (left_dec == 4'd0));
  assign mask_now  = (phase_q == PH_HDR1) ? in_byte_i[7] : mask_q;
  assign bp_fire   = (len_fire && !too_long && !mask_now) ||
                     ((phase_q == PH_MASK) && (left_dec == 4'd0));
  assign bp_rem    = (phase_q == PH_MASK) ? rem_q : len_cand[31:0];
  assign bp_empty  = (bp_rem == 32'd0);
  assign is_msg    = (op_q == OP_TEXT) || (op_q == OP_BINARY);
  assign is_ping   = (op_q == OP_PING);
  assign is_close  = (op_q == OP_CLOSE);

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    fin_d   = fin_q;
    mask_d  = mask_q;
    len_d   = len_q;
    left_d  = left_q;
    key_d   = key_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    if (in_valid_i) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d   = in_byte_i[7];
          op_d    = in_byte_i[3:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = in_byte_i[7];
          len_d  = 64'd0;
          if (in_byte_i[6:0] == LEN_EXT16) begin
            left_d  = EXT16_BYTES;
            phase_d = PH_EXTLEN;
          end else if (in_byte_i[6:0] == LEN_EXT64) begin
            left_d  = EXT64_BYTES;
            phase_d = PH_EXTLEN;
          end else begin
            len_d = len_cand;
          end
        end
        PH_EXTLEN: begin
          len_d  = len_cand;
          left_d = left_dec;
        end
        PH_MASK: begin
          key_d  = {key_q[23:0], in_byte_i};
          left_d = left_dec;
        end
        PH_PAYLOAD: begin
          idx_d = idx_q + 2'd1;
          rem_d = rem_dec;
          if (rem_last) begin
            phase_d = is_close ? PH_STOPPED : PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_STOPPED;
        end
      endcase

      if (len_fire) begin
        if (too_long) begin
          phase_d = PH_STOPPED;
        end else begin
          rem_d = len_cand[31:0];
          key_d = 32'd0;
          if (mask_now) begin
            left_d  = KEY_BYTES;
            phase_d = PH_MASK;
          end
        end
      end

      if (bp_fire) begin
        idx_d = 2'd0;
        if (!bp_empty) begin
          phase_d = PH_PAYLOAD;
        end else if (is_close) begin
          phase_d = PH_STOPPED;
        end else begin
          phase_d = PH_HDR0;
        end
      end
    end
  end

  // result
  always_comb begin
    res_valid_o   = 1'b0;
    res_o.ev      = EV_MSG_BYTE;
    res_o.data    = 8'd0;
    res_o.opcode  = op_q;
    res_o.fin     = fin_q;
    res_o.last    = 1'b1;
    if (in_valid_i) begin
      if (len_fire && too_long) begin
        res_valid_o = 1'b1;
        res_o.ev    = EV_TOO_LONG;
      end else if (bp_fire && bp_empty) begin
        res_valid_o = is_msg || is_ping || is_close;
        if (is_msg) begin
          res_o.ev = EV_EMPTY_MSG;
        end else if (is_ping) begin
          res_o.ev = EV_EMPTY_PING;
        end else begin
          res_o.ev = EV_CLOSE;
        end
      end else if (phase_q == PH_PAYLOAD) begin
        res_o.last = rem_last;
        if (is_msg || is_ping) begin
          res_valid_o = 1'b1;
          res_o.ev    = is_msg ? EV_MSG_BYTE : EV_PING_BYTE;
          res_o.data  = in_byte_i ^ key_byte;
        end else if (is_close && rem_last) begin
          res_valid_o = 1'b1;
          res_o.ev    = EV_CLOSE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      op_q    <= 4'd0;
      fin_q   <= 1'b0;
      mask_q  <= 1'b0;
      len_q   <= 64'd0;
      left_q  <= 4'd0;
      key_q   <= 32'd0;
      rem_q   <= 32'd0;
      idx_q   <= 2'd0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      fin_q   <= fin_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      left_q  <= left_d;
      key_q   <= key_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
    end
  end

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STOPPED |=> phase_q == PH_STOPPED)
    else $error("left stopped phase");

  a_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.ev == EV_CLOSE || res_o.ev == EV_TOO_LONG)
      |=> phase_q == PH_STOPPED)
    else $error("close or too-long event did not stop parser");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != 32'd0)
    else $error("payload phase with zero bytes remaining");

endmodule

`default_nettype wire

FILE: rtl/wsd_out_buf.sv
`default_nettype none

module wsd_out_buf import wsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire res_t in_res_i,
  output      logic in_ready_o,
  output      logic out_valid_o,
  output      res_t out_res_o,
  input  wire logic out_ready_i
);

  res_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_res_o   = ent_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= in_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> in_ready_o)
    else $error("result offered while buffer full");

endmodule

`default_nettype wire
